### rtl/core/fir_filter_streaming_assert.svh
// ----------------------------------------------------------------------------
// fir_filter_streaming_assert.svh
// Assertion macros for the FIR filter RTL. Clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_STREAMING_ASSERT_SVH
`define FIR_FILTER_STREAMING_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FIR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/fir_pkg.sv
// ----------------------------------------------------------------------------
// fir_pkg
// Widths, reset constants and shared types of the streaming FIR filter.
// ----------------------------------------------------------------------------
package fir_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int FRAC_W    = 15;
  localparam int CFG_IDX_W = 8;

  localparam logic signed [COEF_W-1:0] COEF_UNITY = 16'sh7FFF;
  localparam logic signed [COEF_W-1:0] COEF_ZERO  = 16'sh0000;

  // Per-beat side information carried alongside the product into the output stage
  typedef struct packed {
    logic                       filt;
    logic signed [SAMPLE_W-1:0] pass;
  } fir_item_t;

endpackage

### rtl/core/fir_cell.sv
// ----------------------------------------------------------------------------
// fir_cell
// One tap of the transposed chain: holds one history sample and one partial
// sum, and hands both to its lower neighbour on every shift.
// ----------------------------------------------------------------------------
module fir_cell #(
  parameter int ACC_W = 35
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 shift_en,
  input  logic                                 clr,
  input  logic signed [fir_pkg::COEF_W-1:0]    coef,
  input  logic signed [fir_pkg::SAMPLE_W-1:0]  x_feed,
  input  logic signed [fir_pkg::SAMPLE_W-1:0]  hist_in,
  input  logic signed [ACC_W-1:0]              sum_in,
  output logic signed [fir_pkg::SAMPLE_W-1:0]  hist_out,
  output logic signed [ACC_W-1:0]              sum_out
);
  import fir_pkg::*;

  logic signed [SAMPLE_W-1:0] hist_r;
  logic signed [ACC_W-1:0]    sum_r;
  logic signed [ACC_W-1:0]    sum_nxt;
  logic signed [PROD_W-1:0]   prod;

  assign prod    = coef * x_feed;
  assign sum_nxt = sum_in + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      sum_r  <= '0;
    end else begin
      if (shift_en) begin
        hist_r <= hist_in;
      end
      // clear wins: a coefficient write restarts the sums from zero
      if (clr) begin
        sum_r <= '0;
      end else if (shift_en) begin
        sum_r <= sum_nxt;
      end
    end
  end

  assign hist_out = hist_r;
  assign sum_out  = sum_r;

endmodule

### rtl/core/fir_out.sv
// ----------------------------------------------------------------------------
// fir_out
// Output pipe: registers the newest-tap product with the chain's partial sum, then
// adds, rounds and saturates into the output register, or takes the raw sample on pass-through beats.
// ----------------------------------------------------------------------------
module fir_out #(
  parameter int ACC_W = 35
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_fire,
  input  fir_pkg::fir_item_t                   item,
  input  logic signed [fir_pkg::COEF_W-1:0]    coef,
  input  logic signed [fir_pkg::SAMPLE_W-1:0]  x,
  input  logic signed [ACC_W-1:0]              psum,
  output logic                                 up_ready,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [15:0]                          out_tdata,  // [15:0] sample_out
  output logic [0:0]                           out_tuser   // [0] filtered
);
  import fir_pkg::*;

  localparam int Q_W = ACC_W - FRAC_W;
  localparam logic signed [Q_W-1:0]   Q_MAX      = Q_W'(32767);
  localparam logic signed [Q_W-1:0]   Q_MIN      = Q_W'(-32768);
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_W - 1);

  logic                       a_valid_r;
  logic signed [PROD_W-1:0]   a_prod_r;
  logic signed [ACC_W-1:0]    a_sum_r;
  fir_item_t                  a_item_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_data_r;
  logic                       out_filt_r;

  logic                       b_adv;
  logic signed [ACC_W-1:0]    acc;
  logic signed [Q_W-1:0]      q;
  logic signed [SAMPLE_W-1:0] sat;
  logic signed [SAMPLE_W-1:0] out_data_nxt;

  assign b_adv    = !out_valid_r || out_tready;
  assign up_ready = !a_valid_r || b_adv;

  // round to nearest, ties up: add half an LSB then floor
  assign acc = a_sum_r + {{(ACC_W-PROD_W){a_prod_r[PROD_W-1]}}, a_prod_r} + ROUND_BIAS;
  assign q   = acc[ACC_W-1:FRAC_W];

  always_comb begin
    if (q > Q_MAX) begin
      sat = 16'sh7FFF;
    end else if (q < Q_MIN) begin
      sat = 16'sh8000;
    end else begin
      sat = q[SAMPLE_W-1:0];
    end
    out_data_nxt = a_item_r.filt ? sat : a_item_r.pass;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (up_ready) begin
        a_valid_r <= in_fire;
      end
      if (b_adv) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_prod_r <= coef * x;
      a_sum_r  <= psum;
      a_item_r <= item;
    end
    if (b_adv && a_valid_r) begin
      out_data_r <= out_data_nxt;
      out_filt_r <= a_item_r.filt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_filt_r;

endmodule

### rtl/core/fir_filter_streaming.sv
// ----------------------------------------------------------------------------
// fir_filter_streaming
// Streaming FIR filter over framed Q1.15 samples, transposed tap chain.
// ----------------------------------------------------------------------------
// Input beats carry sample_in in in_tdata[15:0] and frame_start in in_tuser[0];
// each beat gives exactly one output beat with sample_out in out_tdata[15:0]
// and filtered in out_tuser[0]. The first TAPS-1 beats of a frame pass through
// with filtered low; after that the output is the Q1.15 dot product of the
// coefficients with the window (coef_0 on the oldest sample), rounded to
// nearest and saturated to 16 bits.
// Throughput is one beat per cycle unless a replay, cfg_valid or a held
// output drops in_tready; an accepted beat is registered in the product
// stage, then in the output register that drives out_tvalid. The tap chain
// takes one multiply-add per cell per beat. cfg_index selects coef_<index>,
// cfg_data holds the value; indexes of TAPS and above are dropped. Each write
// rebuilds the partial sums by replaying the held history through the chain,
// with in_tready and cfg_ready low meanwhile. Reset clears the history and
// sums, sets coef_TAPS-1 to 32767 and the rest to zero. When out_tready is low
// the output and one staged beat are held; in_tready drops once both are full.
// ----------------------------------------------------------------------------
`include "fir_filter_streaming_assert.svh"

module fir_filter_streaming #(
  parameter int TAPS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [15:0]                      in_tdata,   // [15:0] sample_in
  input  logic [0:0]                       in_tuser,   // [0] frame_start
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [15:0]                      out_tdata,  // [15:0] sample_out
  output logic [0:0]                       out_tuser,  // [0] filtered
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fir_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fir_pkg::COEF_W-1:0]       cfg_data
);
  import fir_pkg::*;

  localparam int HIST  = TAPS - 1;
  localparam int CNT_W = $clog2(TAPS);
  localparam int ACC_W = PROD_W + $clog2(TAPS);

  logic signed [COEF_W-1:0]   coef_r [TAPS];
  logic [CNT_W-1:0]           fill_r;
  logic [CNT_W-1:0]           fill_nxt;
  logic [CNT_W-1:0]           fill_eff;
  logic [CNT_W-1:0]           rep_r;
  logic [CNT_W-1:0]           rep_nxt;
  logic                       busy;
  logic                       in_fire;
  logic                       cfg_fire;
  logic                       stage_ready;
  logic                       shift_en;
  logic signed [SAMPLE_W-1:0] x_in;
  logic signed [SAMPLE_W-1:0] x_feed;
  logic signed [SAMPLE_W-1:0] hist_w [HIST];
  logic signed [ACC_W-1:0]    sum_w  [HIST];
  fir_item_t                  item;

  assign busy      = (rep_r != '0);
  assign cfg_ready = !busy;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_tready = stage_ready && !busy && !cfg_valid;
  assign in_fire   = in_tvalid && in_tready;
  assign x_in      = $signed(in_tdata);

  // during replay, rotate the oldest sample back in at the top of the chain
  assign x_feed   = busy ? hist_w[0] : x_in;
  assign shift_en = in_fire || busy;

  always_comb begin
    fill_eff  = in_tuser[0] ? '0 : fill_r;
    item.filt = (fill_eff == CNT_W'(HIST));
    item.pass = x_in;
    fill_nxt  = item.filt ? fill_eff : fill_eff + CNT_W'(1);
    if (cfg_fire) begin
      rep_nxt = CNT_W'(HIST);
    end else if (busy) begin
      rep_nxt = rep_r - CNT_W'(1);
    end else begin
      rep_nxt = rep_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      rep_r  <= '0;
      for (int i = 0; i < TAPS; i++) begin
        coef_r[i] <= (i == TAPS - 1) ? COEF_UNITY : COEF_ZERO;
      end
    end else begin
      rep_r <= rep_nxt;
      if (in_fire) begin
        fill_r <= fill_nxt;
      end
      for (int i = 0; i < TAPS; i++) begin
        if (cfg_fire && cfg_index == CFG_IDX_W'(i)) begin
          coef_r[i] <= $signed(cfg_data);
        end
      end
    end
  end

  // cell i holds history sample i (oldest first) and the partial sum that
  // becomes the output after i+1 further beats
  for (genvar i = 0; i < HIST; i++) begin : g_cell
    logic signed [SAMPLE_W-1:0] hist_in;
    logic signed [ACC_W-1:0]    sum_in;

    if (i == HIST - 1) begin : g_top
      assign hist_in = x_feed;
      assign sum_in  = '0;
    end else begin : g_mid
      assign hist_in = hist_w[i+1];
      assign sum_in  = sum_w[i+1];
    end

    fir_cell #(
      .ACC_W (ACC_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .clr      (cfg_fire),
      .coef     (coef_r[HIST-1-i]),
      .x_feed   (x_feed),
      .hist_in  (hist_in),
      .sum_in   (sum_in),
      .hist_out (hist_w[i]),
      .sum_out  (sum_w[i])
    );
  end

  fir_out #(
    .ACC_W (ACC_W)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .item       (item),
    .coef       (coef_r[TAPS-1]),
    .x          (x_in),
    .psum       (sum_w[0]),
    .up_ready   (stage_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `FIR_ASSERT_SAME(a_replay_blocks, busy, !in_tready && !cfg_ready, "beat taken during replay")
  `FIR_ASSERT_NEXT(a_cfg_replay, cfg_fire, rep_r == CNT_W'(HIST), "replay not started on write")
  `FIR_ASSERT_NEXT(a_frame_fill, in_fire && in_tuser[0], fill_r == CNT_W'(1), "frame start fill")
  `FIR_ASSERT_SAME(a_fill_range, 1'b1, fill_r <= CNT_W'(HIST), "fill count out of range")

endmodule
